// File: rtl/edmcdi_pkg.sv
// Shared types and constants of the edge-directed motion-compensated deinterlacer.
package edmcdi_pkg;

    localparam int PIX_W = 8;
    localparam int CFG_W = 13;
    localparam int POS_W = 12;

    localparam logic [CFG_W-1:0] MAX_WIDTH  = 13'd4096;
    localparam logic [CFG_W-1:0] MAX_HEIGHT = 13'd4096;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET   = 13'd720;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    // Configuration register indexes.
    localparam logic REG_LINE_WIDTH   = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [55:0]      src_above;
        logic [55:0]      src_below;
        logic [39:0]      ref_above;
        logic [39:0]      ref_below;
        logic [PIX_W-1:0] ref_centre;
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
    } item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             was_interpolated;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] line_width;
        logic [CFG_W-1:0] frame_height;
    } cfg_t;

    // Reference-minus-source differences along the winning direction.
    typedef struct packed {
        logic signed [8:0] d0;
        logic signed [8:0] d1;
    } diff_pair_t;

endpackage

// File: rtl/edmcdi_cfg_regs.sv
// Configuration registers: line width and frame height with saturation on write.
module edmcdi_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [edmcdi_pkg::CFG_W-1:0] cfg_data,
    output edmcdi_pkg::cfg_t           cfg
);

    logic [edmcdi_pkg::CFG_W-1:0] line_width_reg;
    logic [edmcdi_pkg::CFG_W-1:0] line_width_next;
    logic [edmcdi_pkg::CFG_W-1:0] frame_height_reg;
    logic [edmcdi_pkg::CFG_W-1:0] frame_height_next;

    always_comb
    begin
        line_width_next   = line_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                edmcdi_pkg::REG_LINE_WIDTH:
                begin
                    line_width_next = (cfg_data > edmcdi_pkg::MAX_WIDTH) ?
                                      edmcdi_pkg::MAX_WIDTH : cfg_data;
                end
                edmcdi_pkg::REG_FRAME_HEIGHT:
                begin
                    frame_height_next = (cfg_data > edmcdi_pkg::MAX_HEIGHT) ?
                                        edmcdi_pkg::MAX_HEIGHT : cfg_data;
                end
                default:
                begin
                    line_width_next   = line_width_reg;
                    frame_height_next = frame_height_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= edmcdi_pkg::LINE_WIDTH_RESET;
            frame_height_reg <= edmcdi_pkg::FRAME_HEIGHT_RESET;
        end
        else
        begin
            line_width_reg   <= line_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    assign cfg.line_width   = line_width_reg;
    assign cfg.frame_height = frame_height_reg;

    // Saturation on write keeps both registers within the supported frame size.
    a_cfg_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        line_width_reg <= edmcdi_pkg::MAX_WIDTH && frame_height_reg <= edmcdi_pkg::MAX_HEIGHT)
        else $error("configuration register above its maximum");

endmodule

// File: rtl/edmcdi_border.sv
// Border test: decides whether the output position is interpolated or passed through.
module edmcdi_border (
    input  logic [edmcdi_pkg::POS_W-1:0] column,
    input  logic [edmcdi_pkg::POS_W-1:0] row,
    input  edmcdi_pkg::cfg_t             cfg,
    output logic                         interp
);

    logic        above_ok;
    logic        rows_left;
    logic [12:0] rows_below;
    logic [24:0] span;
    logic [12:0] col_plus1;
    logic        below_ok;

    // The first pixel before the position must lie inside the frame. On row zero
    // that needs the column beyond the whole line; column zero of row one fails.
    always_comb
    begin
        above_ok = ((row != '0) &&
                    !((column == '0) && ((row == 12'd1) || (cfg.line_width == '0)))) ||
                   ((row == '0) && ({1'b0, column} > cfg.line_width));
    end

    // The pixel after the position must lie before the end of the plane, which
    // reduces to column + 1 < width * (height - row - 1).
    assign rows_left  = {1'b0, cfg.frame_height} > ({2'b00, row} + 14'd1);
    assign rows_below = cfg.frame_height - {1'b0, row} - 13'd1;
    assign span       = {12'b0, cfg.line_width} * {13'b0, rows_below[11:0]};
    assign col_plus1  = {1'b0, column} + 13'd1;
    assign below_ok   = rows_left && ({12'b0, col_plus1} < span);

    assign interp = above_ok && below_ok;

endmodule

// File: rtl/edmcdi_dir_search.sv
// Edge direction search: scores five directions and picks the reference differences.
module edmcdi_dir_search (
    input  logic [55:0]                  src_above,
    input  logic [55:0]                  src_below,
    input  logic [39:0]                  ref_above,
    input  logic [39:0]                  ref_below,
    input  logic [edmcdi_pkg::POS_W-1:0] column,
    input  logic [edmcdi_pkg::CFG_W-1:0] line_width,
    output edmcdi_pkg::diff_pair_t       diffs
);

    function automatic logic [7:0] pix(input logic [55:0] word, input int idx);
        return word[idx*8 +: 8];
    endfunction

    function automatic logic [7:0] absdiff(input logic [7:0] p, input logic [7:0] q);
        return (p > q) ? (p - q) : (q - p);
    endfunction

    // Sum of absolute differences along direction j: above columns shift by +j,
    // below columns by -j.
    function automatic logic [9:0] dir_sad(input logic [55:0] a, input logic [55:0] b,
                                           input int j);
        logic [9:0] acc;
        acc = '0;
        for (int k = -1; k <= 1; k++)
        begin
            acc = acc + {2'b00, absdiff(pix(a, 3 + k + j), pix(b, 3 + k - j))};
        end
        return acc;
    endfunction

    function automatic logic signed [8:0] diff(input logic [7:0] r, input logic [7:0] s);
        return $signed({1'b0, r}) - $signed({1'b0, s});
    endfunction

    function automatic logic signed [10:0] score(input logic [9:0] sad);
        return $signed({1'b0, sad});
    endfunction

    logic [55:0] ra_w;
    logic [55:0] rb_w;
    logic [9:0]  sad_z;
    logic [9:0]  sad_m1;
    logic [9:0]  sad_m2;
    logic [9:0]  sad_p1;
    logic [9:0]  sad_p2;
    logic        near_ok;
    logic        far_ok;
    logic signed [10:0] best;

    assign ra_w = {16'b0, ref_above};
    assign rb_w = {16'b0, ref_below};

    assign sad_z  = dir_sad(src_above, src_below, 0);
    assign sad_m1 = dir_sad(src_above, src_below, -1);
    assign sad_m2 = dir_sad(src_above, src_below, -2);
    assign sad_p1 = dir_sad(src_above, src_below, 1);
    assign sad_p2 = dir_sad(src_above, src_below, 2);

    // Column gates: 2 <= x <= w-3 for the near directions, 3 <= x <= w-4 for the far.
    assign near_ok = (column >= 12'd2) && (({1'b0, column} + 13'd3) <= line_width);
    assign far_ok  = (column >= 12'd3) && (({1'b0, column} + 13'd4) <= line_width);

    always_comb
    begin
        best     = score(sad_z) - 11'sd1;
        diffs.d0 = diff(pix(ra_w, 2), pix(src_above, 3));
        diffs.d1 = diff(pix(rb_w, 2), pix(src_below, 3));

        if (near_ok && (score(sad_m1) < best))
        begin
            best     = score(sad_m1);
            diffs.d0 = diff(pix(ra_w, 1), pix(src_above, 2));
            diffs.d1 = diff(pix(rb_w, 3), pix(src_below, 4));
            if (far_ok && (score(sad_m2) < best))
            begin
                best     = score(sad_m2);
                diffs.d0 = diff(pix(ra_w, 0), pix(src_above, 1));
                diffs.d1 = diff(pix(rb_w, 4), pix(src_below, 5));
            end
        end

        if (near_ok && (score(sad_p1) < best))
        begin
            best     = score(sad_p1);
            diffs.d0 = diff(pix(ra_w, 3), pix(src_above, 4));
            diffs.d1 = diff(pix(rb_w, 1), pix(src_below, 2));
            if (far_ok && (score(sad_p2) < best))
            begin
                diffs.d0 = diff(pix(ra_w, 4), pix(src_above, 5));
                diffs.d1 = diff(pix(rb_w, 0), pix(src_below, 1));
            end
        end
    end

endmodule

// File: rtl/edge_directed_mc_deinterlace_pixel.sv
// Top level of the edge-directed motion-compensated deinterlacer pixel engine.
//
// One transaction carries the source and reference windows for one output pixel
// and produces exactly one result, in this order: the
// transaction is captured in an input register, the direction search, border
// test and correction run in one combinational pass, and the result register
// drives result with done high for a single cycle. A new transaction is accepted
// in every clock cycle, so busy is always low and the block sustains one pixel
// per clock; the critical path is the 13x12-bit border multiply in parallel with
// the direction compare chain. The receiver cannot stall, so results must be
// taken in the cycle that done is high. Configuration writes take effect at the
// next clock edge and must only be issued while no transaction is in flight.
module edge_directed_mc_deinterlace_pixel (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  edmcdi_pkg::item_t            item,
    output logic                         done,
    output edmcdi_pkg::result_t          result,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [edmcdi_pkg::CFG_W-1:0] cfg_data
);

    edmcdi_pkg::cfg_t       cfg;
    edmcdi_pkg::item_t      item_reg;
    logic                   valid_reg;
    edmcdi_pkg::result_t    result_reg;
    edmcdi_pkg::result_t    result_next;
    logic                   done_reg;
    edmcdi_pkg::diff_pair_t diffs;
    logic                   interp;

    logic signed [9:0]  sum_d;
    logic [8:0]         raw0;
    logic [8:0]         raw1;
    logic [7:0]         mag0;
    logic [7:0]         mag1;
    logic [7:0]         gap;
    logic signed [10:0] blend;
    logic signed [10:0] blend_adj;
    logic signed [10:0] half_blend;
    logic signed [11:0] corrected;
    logic [7:0]         clamped;

    // The pipeline never stalls, so transactions are always accepted.
    assign busy = 1'b0;

    edmcdi_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item;
    end

    edmcdi_dir_search u_dir (
        .src_above  (item_reg.src_above),
        .src_below  (item_reg.src_below),
        .ref_above  (item_reg.ref_above),
        .ref_below  (item_reg.ref_below),
        .column     (item_reg.column),
        .line_width (cfg.line_width),
        .diffs      (diffs)
    );

    edmcdi_border u_border (
        .column (item_reg.column),
        .row    (item_reg.row),
        .cfg    (cfg),
        .interp (interp)
    );

    // Correction: the reference centre is moved by half of the blended sum of
    // the two differences, where the blend pulls the sum toward zero by half the
    // gap between their magnitudes. Both halvings truncate toward zero.
    always_comb
    begin
        sum_d = $signed({diffs.d0[8], diffs.d0}) + $signed({diffs.d1[8], diffs.d1});
        raw0  = diffs.d0[8] ? (~diffs.d0 + 9'd1) : diffs.d0;
        raw1  = diffs.d1[8] ? (~diffs.d1 + 9'd1) : diffs.d1;
        mag0  = raw0[7:0];
        mag1  = raw1[7:0];
        gap   = (mag0 >= mag1) ? (mag0 - mag1) : (mag1 - mag0);
        if (sum_d > 10'sd0)
        begin
            blend = $signed({sum_d[9], sum_d}) - $signed({4'b0000, gap[7:1]});
        end
        else
        begin
            blend = $signed({sum_d[9], sum_d}) + $signed({4'b0000, gap[7:1]});
        end
        blend_adj  = blend + $signed({10'b0, blend[10]});
        half_blend = blend_adj >>> 1;
        corrected  = $signed({4'b0000, item_reg.ref_centre}) -
                     $signed({half_blend[10], half_blend});
        if (corrected[11])
        begin
            clamped = 8'd0;
        end
        else if (corrected > 12'sd255)
        begin
            clamped = 8'd255;
        end
        else
        begin
            clamped = corrected[7:0];
        end

        // Border positions pass the reference centre through untouched.
        result_next.pixel_out        = interp ? clamped : item_reg.ref_centre;
        result_next.was_interpolated = interp;
    end

    // Result register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every result strobe traces back to an accepted transaction, through the input and result registers.
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result strobe without an accepted transaction");

    // A passthrough result carries the reference centre of its transaction.
    a_passthrough_centre: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.was_interpolated) |-> (result.pixel_out == $past(item.ref_centre, 2)))
        else $error("passthrough pixel differs from reference centre");

    // Column zero of row one always fails the border test, whatever the plane size.
    a_row_one_column_zero_border: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.was_interpolated) |->
            !(($past(item.column, 2) == '0) && ($past(item.row, 2) == 12'd1)))
        else $error("column zero of row one was interpolated");

endmodule

// File: sim/tb_edge_directed_mc_deinterlace_pixel.sv
// Self-checking testbench for the edge-directed motion-compensated deinterlacer pixel engine.
module tb_edge_directed_mc_deinterlace_pixel;

    import edmcdi_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int TAIL_CYCLES  = 4;
    // A correct run ends well before this limit, so it only catches a hang.
    localparam int CYCLE_LIMIT  = 100000;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 95;

    // Scoreboard: keeps its own copy of the two line/frame registers, computes the
    // expected pixel for every accepted transaction and checks results in order.
    class pixel_scoreboard;
        int unsigned line_width;
        int unsigned frame_height;
        result_t     expected_pixels[$];
        int          mismatch_count;

        function new();
            line_width     = LINE_WIDTH_RESET;
            frame_height   = FRAME_HEIGHT_RESET;
            mismatch_count = 0;
        endfunction

        // Written values above the supported maximum saturate.
        function void apply_register(logic index, logic [CFG_W-1:0] value);
            if (index == REG_LINE_WIDTH)
                line_width = (value > MAX_WIDTH) ? MAX_WIDTH : value;
            else
                frame_height = (value > MAX_HEIGHT) ? MAX_HEIGHT : value;
        endfunction

        function int pix(logic [55:0] word, int idx);
            return int'(word[idx*8 +: 8]);
        endfunction

        function int magnitude(int v);
            return (v < 0) ? -v : v;
        endfunction

        // Sum of absolute differences along direction dir: above is shifted by +dir,
        // below by -dir, over three neighboring columns.
        function int direction_sad(logic [55:0] above, logic [55:0] below, int dir);
            int total;
            int k;
            total = 0;
            for (k = -1; k <= 1; k++)
                total += magnitude(pix(above, 3 + k + dir) - pix(below, 3 + k - dir));
            return total;
        endfunction

        function result_t deinterlace_pixel(item_t it);
            longint  x, y, w, h;
            int      best, score, d0, d1, sgn, dir, s, a, temp;
            bit      near_ok, far_ok;
            result_t r;
            x = it.column;
            y = it.row;
            w = line_width;
            h = frame_height;
            // Positions whose neighbors fall outside the plane pass the reference through.
            if (!((x - 1) + (y - 1) * w >= 0 && (x + 1) + (y + 1) * w < w * h)) begin
                r.pixel_out        = it.ref_centre;
                r.was_interpolated = 1'b0;
                return r;
            end
            best    = direction_sad(it.src_above, it.src_below, 0) - 1;
            d0      = pix(it.ref_above, 2) - pix(it.src_above, 3);
            d1      = pix(it.ref_below, 2) - pix(it.src_below, 3);
            near_ok = (x >= 2) && (x <= w - 3);
            far_ok  = (x >= 3) && (x <= w - 4);
            for (sgn = -1; sgn <= 1; sgn += 2) begin
                if (near_ok) begin
                    score = direction_sad(it.src_above, it.src_below, sgn);
                    if (score < best) begin
                        best = score;
                        d0   = pix(it.ref_above, 2 + sgn) - pix(it.src_above, 3 + sgn);
                        d1   = pix(it.ref_below, 2 - sgn) - pix(it.src_below, 3 - sgn);
                        // The far direction is only considered once the near one has won.
                        if (far_ok) begin
                            dir   = 2 * sgn;
                            score = direction_sad(it.src_above, it.src_below, dir);
                            if (score < best) begin
                                best = score;
                                d0   = pix(it.ref_above, 2 + dir) - pix(it.src_above, 3 + dir);
                                d1   = pix(it.ref_below, 2 - dir) - pix(it.src_below, 3 - dir);
                            end
                        end
                    end
                end
            end
            // Division on int truncates toward zero, which the correction relies on.
            s    = d0 + d1;
            a    = magnitude(magnitude(d0) - magnitude(d1)) / 2;
            temp = int'(it.ref_centre);
            if (s > 0)
                temp -= (s - a) / 2;
            else
                temp -= (s + a) / 2;
            if (temp < 0)
                temp = 0;
            else if (temp > 255)
                temp = 255;
            r.pixel_out        = 8'(temp);
            r.was_interpolated = 1'b1;
            return r;
        endfunction

        function void note_item(item_t it);
            expected_pixels.push_back(deinterlace_pixel(it));
        endfunction

        function void check_pixel(result_t got);
            result_t want;
            if (expected_pixels.size() == 0) begin
                $error("result with no transaction pending: pixel_out %0d, was_interpolated %0d",
                       got.pixel_out, got.was_interpolated);
                mismatch_count++;
                return;
            end
            want = expected_pixels.pop_front();
            if (got.pixel_out !== want.pixel_out) begin
                $error("pixel_out mismatch: expected %0d, actual %0d",
                       want.pixel_out, got.pixel_out);
                mismatch_count++;
            end
            if (got.was_interpolated !== want.was_interpolated) begin
                $error("was_interpolated mismatch: expected %0d, actual %0d",
                       want.was_interpolated, got.was_interpolated);
                mismatch_count++;
            end
        endfunction

        function void report_leftover();
            if (expected_pixels.size() != 0) begin
                $error("%0d expected results never arrived", expected_pixels.size());
                mismatch_count += expected_pixels.size();
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    item_t            item_bus;
    logic             done;
    result_t          result_bus;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    pixel_scoreboard  sb;
    int               cycle_count = 0;

    edge_directed_mc_deinterlace_pixel DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item_bus),
        .done      (done),
        .result    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Monitor. Everything is driven at the falling edge, so at the rising edge the
    // inputs are stable and the block's registered outputs still hold their
    // pre-edge values. A transaction is taken when start is high and busy is low;
    // a result is taken in the single cycle its done strobe is high.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_item(item_bus);
        if (rst_n && done)
            sb.check_pixel(result_bus);
    end

    // Watchdog against a hang anywhere in the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Builds windows that follow an edge along direction dir: the row below is the
    // row above shifted by 2*dir columns, so that direction scores best unless noise
    // or the column gates get in the way. The reference rows track the source rows
    // with a random drift, which drives the correction term over a wide range.
    function automatic item_t window_item(int dir, int noise, int x, int y, int centre);
        item_t      it;
        logic [7:0] line [15];
        int         i, base, step, drift;
        base  = $urandom_range(0, 255);
        step  = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 40) : 0;
        drift = $urandom_range(0, 1) ? $urandom_range(0, 30) : $urandom_range(0, 255);
        for (i = 0; i < 15; i++)
            line[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'(base + i * step);
        for (i = 0; i < 7; i++) begin
            it.src_above[i*8 +: 8] = 8'(line[i + 4] + $urandom_range(0, noise));
            it.src_below[i*8 +: 8] = 8'(line[i + 4 + 2 * dir] + $urandom_range(0, noise));
        end
        // Reference byte i sits at the same column as source byte i+1.
        for (i = 0; i < 5; i++) begin
            it.ref_above[i*8 +: 8] =
                8'(it.src_above[(i + 1)*8 +: 8] + $urandom_range(0, 2 * drift) - drift);
            it.ref_below[i*8 +: 8] =
                8'(it.src_below[(i + 1)*8 +: 8] + $urandom_range(0, 2 * drift) - drift);
        end
        it.ref_centre = 8'(centre);
        it.column     = 12'(x);
        it.row        = 12'(y);
        return it;
    endfunction

    // Random transaction for the current plane size. Most positions lie inside the
    // plane, a good share sits on the border and gate columns, and a few are anywhere
    // in the 12-bit range. Content is mostly edge-shaped windows, the rest raw noise.
    function automatic item_t random_item(int w, int h);
        item_t       it;
        logic [63:0] bits;
        int          pick, x, y, centre;
        pick = $urandom_range(0, 19);
        if (pick < 12 && w > 0 && h > 0) begin
            x = $urandom_range(0, w - 1);
            y = $urandom_range(0, h - 1);
        end else if (pick < 17) begin
            case ($urandom_range(0, 7))
                0:       x = 0;
                1:       x = 1;
                2:       x = 2;
                3:       x = 3;
                4:       x = w - 4;
                5:       x = w - 3;
                6:       x = w - 2;
                default: x = w - 1;
            endcase
            case ($urandom_range(0, 3))
                0:       y = 0;
                1:       y = 1;
                2:       y = h - 2;
                default: y = h - 1;
            endcase
        end else begin
            x = $urandom_range(0, 4095);
            y = $urandom_range(0, 4095);
        end
        case ($urandom_range(0, 5))
            0:       centre = 0;
            1:       centre = 255;
            default: centre = $urandom_range(0, 255);
        endcase
        if ($urandom_range(0, 3) == 0) begin
            bits          = {$urandom(), $urandom()};
            it.src_above  = bits[55:0];
            bits          = {$urandom(), $urandom()};
            it.src_below  = bits[55:0];
            bits          = {$urandom(), $urandom()};
            it.ref_above  = bits[39:0];
            bits          = {$urandom(), $urandom()};
            it.ref_below  = bits[39:0];
            it.ref_centre = 8'(centre);
            it.column     = 12'(x);
            it.row        = 12'(y);
        end else begin
            case ($urandom_range(0, 2))
                0:       it = window_item($urandom_range(0, 4) - 2, 0, x, y, centre);
                1:       it = window_item($urandom_range(0, 4) - 2, 6, x, y, centre);
                default: it = window_item($urandom_range(0, 4) - 2, 80, x, y, centre);
            endcase
        end
        return it;
    endfunction

    // Offers one transaction after a gap of idle cycles and holds it until taken.
    // Start is touched at most once per falling edge, so back-to-back transactions
    // keep it high without a glitch.
    task automatic send_pixel(item_t it, int gap);
        repeat (gap) begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start    <= 1'b1;
        item_bus <= it;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Drops start and waits until every outstanding transaction has its result.
    task automatic wait_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (sb.expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Writes both registers back to back while the block is idle. The write enable
    // stays high across the two writes and drops once at the end.
    task automatic configure(int width, int height);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LINE_WIDTH;
        cfg_data  <= CFG_W'(width);
        @(posedge clk);
        sb.apply_register(REG_LINE_WIDTH, CFG_W'(width));
        @(negedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= CFG_W'(height);
        @(posedge clk);
        sb.apply_register(REG_FRAME_HEIGHT, CFG_W'(height));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random traffic with bursts of back-to-back transactions mixed with
    // stretches of random gaps, so idle cycles fall on every pipeline stage.
    task automatic run_phase(int count);
        int n, gap, burst_left;
        bit burst;
        burst_left = 0;
        burst      = 1'b0;
        for (n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                burst      = ($urandom_range(0, 2) == 0);
                burst_left = $urandom_range(5, 30);
            end
            burst_left--;
            gap = burst ? 0 : $urandom_range(0, 5);
            send_pixel(random_item(sb.line_width, sb.frame_height), gap);
        end
    endtask

    initial
    begin
        int phase_width  [PHASES];
        int phase_height [PHASES];
        int p;

        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        item_bus  = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_LINE_WIDTH;
        cfg_data  = '0;

        // Plane sizes per phase: the minimum, the maximum, values that saturate,
        // zero width and zero height (everything passes through), a tiny width,
        // a common HD size, the reset size, and a random one at the end.
        phase_width  = '{8, 4096, 8191, 0,  13, 1920, 2, 720, 0};
        phase_height = '{3, 4096, 7000, 5,  0,  1080, 3, 480, 0};
        phase_width[PHASES-1]  = $urandom_range(8, 4096);
        phase_height[PHASES-1] = $urandom_range(3, 4096);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, with the reset plane of 720 by 480.
        // All-zero and all-one windows at an interior position.
        send_pixel(item_t'{56'h0, 56'h0, 40'h0, 40'h0, 8'h00, 12'd100, 12'd100},
                   $urandom_range(0, 5));
        send_pixel(item_t'{{7{8'hFF}}, {7{8'hFF}}, {5{8'hFF}}, {5{8'hFF}}, 8'hFF,
                           12'd100, 12'd100}, $urandom_range(0, 5));
        // Large positive correction drives the pixel below zero; large negative above 255.
        send_pixel(item_t'{56'h0, 56'h0, {5{8'hFF}}, {5{8'hFF}}, 8'h00, 12'd300, 12'd200},
                   $urandom_range(0, 5));
        send_pixel(item_t'{{7{8'hFF}}, {7{8'hFF}}, 40'h0, 40'h0, 8'hFF, 12'd300, 12'd200},
                   $urandom_range(0, 5));
        // Border test: far out of range, the first rows, and the end of the row before the last.
        send_pixel(window_item(0, 255, 4095, 4095, 77), $urandom_range(0, 5));
        send_pixel(window_item(0, 255, 0, 0, 13), $urandom_range(0, 5));
        send_pixel(window_item(0, 255, 0, 1, 200), $urandom_range(0, 5));
        send_pixel(window_item(0, 255, 1, 1, 90), $urandom_range(0, 5));
        send_pixel(window_item(0, 255, 719, 478, 45), $urandom_range(0, 5));
        send_pixel(window_item(0, 255, 718, 478, 180), $urandom_range(0, 5));
        send_pixel(window_item(0, 255, 4095, 0, 66), $urandom_range(0, 5));
        // Clean edges along each of the five directions.
        send_pixel(window_item(-2, 0, 100, 200, 128), $urandom_range(0, 5));
        send_pixel(window_item(-1, 0, 100, 200, 128), $urandom_range(0, 5));
        send_pixel(window_item(0, 0, 100, 200, 128), $urandom_range(0, 5));
        send_pixel(window_item(1, 0, 100, 200, 128), $urandom_range(0, 5));
        send_pixel(window_item(2, 0, 100, 200, 128), $urandom_range(0, 5));
        // Column gates: near and far directions right at and just past their limits.
        send_pixel(window_item(-1, 0, 2, 50, 60), $urandom_range(0, 5));
        send_pixel(window_item(-1, 0, 1, 50, 60), $urandom_range(0, 5));
        send_pixel(window_item(-2, 0, 2, 50, 60), $urandom_range(0, 5));
        send_pixel(window_item(-2, 0, 3, 50, 60), $urandom_range(0, 5));
        send_pixel(window_item(2, 0, 716, 50, 60), $urandom_range(0, 5));
        send_pixel(window_item(2, 0, 717, 50, 60), $urandom_range(0, 5));
        send_pixel(window_item(1, 0, 717, 50, 60), $urandom_range(0, 5));
        send_pixel(window_item(1, 0, 718, 50, 60), $urandom_range(0, 5));
        wait_for_results();

        // Random part, one phase per plane size.
        for (p = 0; p < PHASES; p++) begin
            configure(phase_width[p], phase_height[p]);
            run_phase(PHASE_ITEMS);
            wait_for_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        sb.report_leftover();
        if (sb.mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
